// ===== hdl/sfe_pkg.sv =====
// Shared types and constants for the subtract-from execute unit.
package sfe_pkg;

  // Instruction forms; the codes above FUNC_ZEXT are no-ops
  typedef enum logic [2:0] {
    FUNC_IMM   = 3'd0,
    FUNC_PLAIN = 3'd1,
    FUNC_CARRY = 3'd2,
    FUNC_EXT   = 3'd3,
    FUNC_M1EXT = 3'd4,
    FUNC_ZEXT  = 3'd5
  } func_t;

  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned RESULT_W  = 32;
  localparam int unsigned CR_W      = 4;

  // Architectural flag state: carry, overflow, summary overflow, CR0 (LT,GT,EQ,SO)
  typedef struct packed {
    logic            carry;
    logic            ov;
    logic            so;
    logic [CR_W-1:0] cr0;
  } flags_t;

endpackage

// ===== hdl/sfe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module sfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                    wr_data,
  input  logic                                rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sfe_regfile.sv =====
// Register file: two RAM copies for the RA and RB ports, valid bits, and write forwarding.
module sfe_regfile
  import sfe_pkg::*;
#(
  parameter int REG_COUNT = 32,
  parameter int DW        = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] rd_a_idx,
  input  logic [REG_IDX_W-1:0] rd_b_idx,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_idx,
  input  logic [DW-1:0]        wr_data,
  output logic [DW-1:0]        rd_a_data,
  output logic [DW-1:0]        rd_b_data
);

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [REG_COUNT-1:0] vld;
  logic [DW-1:0]        ram_a_data;
  logic [DW-1:0]        ram_b_data;
  logic [REG_IDX_W-1:0] a_idx;
  logic [REG_IDX_W-1:0] b_idx;
  logic                 a_in;
  logic                 b_in;
  logic                 a_vld;
  logic                 b_vld;
  logic                 fwd_valid;
  logic [REG_IDX_W-1:0] fwd_idx;
  logic [DW-1:0]        fwd_data;
  logic                 a_in_next;
  logic                 b_in_next;

  assign a_in_next = 32'(rd_a_idx) < REG_COUNT;
  assign b_in_next = 32'(rd_b_idx) < REG_COUNT;

  sfe_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(wr_idx)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_a_idx)),
    .rd_data (ram_a_data)
  );

  sfe_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(wr_idx)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_b_idx)),
    .rd_data (ram_b_data)
  );

  // Mark entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[AW'(wr_idx)] <= 1'b1;
    end
  end

  // Capture read-side context and any write landing on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (rd_en) begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_idx    <= rd_a_idx;
      b_idx    <= rd_b_idx;
      a_in     <= a_in_next;
      b_in     <= b_in_next;
      a_vld    <= a_in_next && vld[AW'(rd_a_idx)];
      b_vld    <= b_in_next && vld[AW'(rd_b_idx)];
      fwd_idx  <= wr_idx;
      fwd_data <= wr_data;
    end
  end

  // Select forwarded data, stored data, or zero
  always_comb begin
    if (!a_in) begin
      rd_a_data = '0;
    end else if (fwd_valid && fwd_idx == a_idx) begin
      rd_a_data = fwd_data;
    end else if (a_vld) begin
      rd_a_data = ram_a_data;
    end else begin
      rd_a_data = '0;
    end

    if (!b_in) begin
      rd_b_data = '0;
    end else if (fwd_valid && fwd_idx == b_idx) begin
      rd_b_data = fwd_data;
    end else if (b_vld) begin
      rd_b_data = ram_b_data;
    end else begin
      rd_b_data = '0;
    end
  end

endmodule

// ===== hdl/sfe_alu.sv =====
// Subtract-from datapath: operand select, sum, carry, overflow and CR0 update.
module sfe_alu
  import sfe_pkg::*;
#(
  parameter int DW = 32
) (
  input  func_t                   func,
  input  logic signed [IMM_W-1:0] imm,
  input  logic                    oe,
  input  logic                    rc,
  input  logic [DW-1:0]           a_data,
  input  logic [DW-1:0]           b_data,
  input  flags_t                  flags_in,
  output logic [DW-1:0]           res,
  output logic                    legal,
  output flags_t                  flags_out
);

  logic [DW-1:0] x;
  logic [DW-1:0] y;
  logic          cin;
  logic          upd_ca;
  logic          is_imm;
  logic [DW:0]   sum;
  logic [DW-1:0] s;
  logic          ovf;
  logic          so_new;

  always_comb begin
    x      = ~a_data;
    y      = '0;
    cin    = flags_in.carry;
    upd_ca = 1'b1;
    is_imm = 1'b0;
    legal  = 1'b1;
    // Pick the second operand and carry-in per form
    case (func)
      FUNC_IMM: begin
        y      = DW'(imm);
        cin    = 1'b1;
        is_imm = 1'b1;
      end
      FUNC_PLAIN: begin
        y      = b_data;
        cin    = 1'b1;
        upd_ca = 1'b0;
      end
      FUNC_CARRY: begin
        y   = b_data;
        cin = 1'b1;
      end
      FUNC_EXT: begin
        y = b_data;
      end
      FUNC_M1EXT: begin
        y = '1;
      end
      FUNC_ZEXT: begin
        y = '0;
      end
      default: begin
        legal = 1'b0;
      end
    endcase

    sum    = {1'b0, x} + {1'b0, y} + (DW + 1)'(cin);
    s      = sum[DW-1:0];
    ovf    = ((x[DW-1] ^ s[DW-1]) & (y[DW-1] ^ s[DW-1]));
    so_new = flags_in.so;
    flags_out = flags_in;
    res    = '0;

    // Update flags only for a real instruction
    if (legal) begin
      res = s;
      if (upd_ca) begin
        flags_out.carry = sum[DW];
      end
      if (!is_imm) begin
        if (oe) begin
          flags_out.ov = ovf;
          so_new       = flags_in.so | ovf;
          flags_out.so = so_new;
        end
        if (rc) begin
          flags_out.cr0 = {s[DW-1], !s[DW-1] && (s != '0), s == '0, so_new};
        end
      end
    end
  end

endmodule

// ===== hdl/subtract_from_execute_unit.sv =====
// Top level of the subtract-from execute unit: read stage, execute/write-back stage, output register.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  func dest_reg src_a_reg src_b_reg immediate
//                                            overflow_enable record_enable
//   out      source     out_valid/out_ready  result_value carry_flag overflow_flag
//                                            summary_overflow cr0_field
//
// One item per cycle sustained while the output is not stalled; out_valid rises as the item
// leaves the execute stage. The read stage reads RA and RB from the register file RAMs;
// the execute stage adds, updates flags, writes RT back and loads the output register. A
// write landing on the same edge as the next item's read is forwarded. Reset clears flags
// and the entry valid bits at once, so no clearing pass is needed. A stalled output holds
// the execute stage, which in turn holds the input.
module subtract_from_execute_unit
  import sfe_pkg::*;
#(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              func,
  input  logic [REG_IDX_W-1:0]    dest_reg,
  input  logic [REG_IDX_W-1:0]    src_a_reg,
  input  logic [REG_IDX_W-1:0]    src_b_reg,
  input  logic signed [IMM_W-1:0] immediate,
  input  logic                    overflow_enable,
  input  logic                    record_enable,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RESULT_W-1:0]     result_value,
  output logic                    carry_flag,
  output logic                    overflow_flag,
  output logic                    summary_overflow,
  output logic [CR_W-1:0]         cr0_field
);

  logic                    in_fire;
  logic                    s1_valid;
  logic                    s1_adv;
  func_t                   s1_func;
  logic [REG_IDX_W-1:0]    s1_dest;
  logic signed [IMM_W-1:0] s1_imm;
  logic                    s1_oe;
  logic                    s1_rc;
  logic [DATA_WIDTH-1:0]   a_data;
  logic [DATA_WIDTH-1:0]   b_data;
  logic [DATA_WIDTH-1:0]   alu_res;
  logic                    alu_legal;
  flags_t                  flags;
  flags_t                  flags_next;
  logic                    wr_en;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_adv && alu_legal && (32'(s1_dest) < REG_COUNT);

  sfe_regfile #(.REG_COUNT(REG_COUNT), .DW(DATA_WIDTH)) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_a_idx  (src_a_reg),
    .rd_b_idx  (src_b_reg),
    .wr_en     (wr_en),
    .wr_idx    (s1_dest),
    .wr_data   (alu_res),
    .rd_a_data (a_data),
    .rd_b_data (b_data)
  );

  sfe_alu #(.DW(DATA_WIDTH)) u_alu (
    .func      (s1_func),
    .imm       (s1_imm),
    .oe        (s1_oe),
    .rc        (s1_rc),
    .a_data    (a_data),
    .b_data    (b_data),
    .flags_in  (flags),
    .res       (alu_res),
    .legal     (alu_legal),
    .flags_out (flags_next)
  );

  // Track the execute stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Hold the item's fields for the execute stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func <= func_t'(func);
      s1_dest <= dest_reg;
      s1_imm  <= immediate;
      s1_oe   <= overflow_enable;
      s1_rc   <= record_enable;
    end
  end

  // Commit flags as each item leaves the execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_adv) begin
      flags <= flags_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_value     <= RESULT_W'(alu_res);
      carry_flag       <= flags_next.carry;
      overflow_flag    <= flags_next.ov;
      summary_overflow <= flags_next.so;
      cr0_field        <= flags_next.cr0;
    end
  end

  // Never take a new item while the execute stage is held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_fire)
    else $error("item accepted while execute stage stalled");

  // Summary overflow is sticky until reset
  a_so_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(flags.so))
    else $error("summary overflow cleared without reset");

  // Register writes happen only as a legal item retires
  a_write_on_retire: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_adv && alu_legal))
    else $error("register write outside retirement");

  // A retiring item always appears at the output on the next edge
  a_retire_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("retired item missing from output");

endmodule
